// ----- sv/nearest_rect_select_top_macros.svh -----
// Assertion macros used by the nearest rectangle select top level.
`ifndef NEAREST_RECT_SELECT_TOP_MACROS_SVH
`define NEAREST_RECT_SELECT_TOP_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define NRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define NRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/nrs_pkg.sv -----
// Shared constants and types of the nearest rectangle select block.
package nrs_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int MAX_RECTS_DEF  = 256;
  localparam int INDEX_LIMIT    = 256;
  localparam int INDEX_BITS     = 8;
  localparam int CFG_IDX_BITS   = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CARET_X = 1'b0,
    REG_CARET_Y = 1'b1
  } cfg_reg_t;

  // Control that travels with each request down the pipeline.
  typedef struct packed {
    logic valid;
    logic qual;
    logic last;
  } stage_ctl_t;

  typedef struct packed {
    logic last_fire;
    logic list_clear;
  } acc_status_t;

endpackage

// ----- sv/nrs_rect_if.sv -----
// Request channel carrying one candidate rectangle.
interface nrs_rect_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] rect_x;
  logic signed [COORD_BITS-1:0] rect_y;
  logic signed [COORD_BITS-1:0] rect_width;
  logic signed [COORD_BITS-1:0] rect_height;
  logic                         last_rect;

  modport source (output valid, rect_x, rect_y, rect_width, rect_height, last_rect,
                  input ready);
  modport sink (input valid, rect_x, rect_y, rect_width, rect_height, last_rect,
                output ready);
endinterface

// ----- sv/nrs_result_if.sv -----
// Result channel carrying the selection for one rectangle list.
interface nrs_result_if;
  import nrs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [INDEX_BITS-1:0] best_index;
  logic                  overflow;

  modport source (output valid, found, best_index, overflow, input ready);
  modport sink (input valid, found, best_index, overflow, output ready);
endinterface

// ----- sv/nrs_gap.sv -----
// Input register and per-axis gap from the caret to the rectangle span.
module nrs_gap #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [COORD_BITS-1:0] caret_x,
  input  logic signed [COORD_BITS-1:0] caret_y,
  nrs_rect_if.sink                     in_rect,
  input  logic                         up_ready,
  output nrs_pkg::stage_ctl_t          s1_ctl,
  output logic [COORD_BITS-1:0]        gap_x,
  output logic [COORD_BITS-1:0]        gap_y
);
  import nrs_pkg::*;

  localparam int EW = COORD_BITS + 2;

  logic                         s0_valid_r;
  logic                         s0_last_r;
  logic signed [COORD_BITS-1:0] s0_x_r;
  logic signed [COORD_BITS-1:0] s0_y_r;
  logic signed [COORD_BITS-1:0] s0_w_r;
  logic signed [COORD_BITS-1:0] s0_h_r;

  logic                         s1_valid_r;
  logic                         s1_qual_r;
  logic                         s1_last_r;
  logic [COORD_BITS-1:0]        gap_x_r;
  logic [COORD_BITS-1:0]        gap_y_r;

  logic                         gap_x_nxt;
  logic [COORD_BITS-1:0]        gx_nxt;
  logic [COORD_BITS-1:0]        gy_nxt;
  logic                         qual_nxt;
  logic                         s1_free;
  logic                         s0_fire;

  // Distance from pt to [st, st+sz-1]; zero inside. Fits COORD_BITS unsigned for sz > 0.
  function automatic logic [COORD_BITS-1:0] span_gap(
    input logic signed [COORD_BITS-1:0] pt,
    input logic signed [COORD_BITS-1:0] st,
    input logic signed [COORD_BITS-1:0] sz
  );
    logic signed [EW-1:0] p_e;
    logic signed [EW-1:0] s_e;
    logic signed [EW-1:0] z_e;
    logic signed [EW-1:0] e_e;
    logic signed [EW-1:0] diff;
    p_e  = {{2{pt[COORD_BITS-1]}}, pt};
    s_e  = {{2{st[COORD_BITS-1]}}, st};
    z_e  = {{2{sz[COORD_BITS-1]}}, sz};
    e_e  = s_e + z_e - EW'(1);
    if (p_e < s_e) begin
      diff = s_e - p_e;
    end else if (p_e > e_e) begin
      diff = p_e - e_e;
    end else begin
      diff = '0;
    end
    return diff[COORD_BITS-1:0];
  endfunction

  assign s1_free       = !s1_valid_r || up_ready;
  assign s0_fire       = s0_valid_r && s1_free;
  assign in_rect.ready = !s0_valid_r || s0_fire;

  always_comb begin
    gx_nxt    = span_gap(caret_x, s0_x_r, s0_w_r);
    gy_nxt    = span_gap(caret_y, s0_y_r, s0_h_r);
    // Skip rectangles whose width or height is zero or negative.
    qual_nxt  = !s0_w_r[COORD_BITS-1] && (|s0_w_r) && !s0_h_r[COORD_BITS-1] && (|s0_h_r);
    gap_x_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_rect.ready) begin
      s0_valid_r <= in_rect.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rect.valid && in_rect.ready) begin
      s0_x_r    <= in_rect.rect_x;
      s0_y_r    <= in_rect.rect_y;
      s0_w_r    <= in_rect.rect_width;
      s0_h_r    <= in_rect.rect_height;
      s0_last_r <= in_rect.last_rect;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      gap_x_r   <= gx_nxt | {COORD_BITS{gap_x_nxt}};
      gap_y_r   <= gy_nxt;
      s1_qual_r <= qual_nxt;
      s1_last_r <= s0_last_r;
    end
  end

  assign s1_ctl.valid = s1_valid_r;
  assign s1_ctl.qual  = s1_qual_r;
  assign s1_ctl.last  = s1_last_r;
  assign gap_x        = gap_x_r;
  assign gap_y        = gap_y_r;

endmodule

// ----- sv/nrs_dist.sv -----
// Squares of the two axis gaps, registered.
module nrs_dist #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  nrs_pkg::stage_ctl_t     s1_ctl,
  input  logic [COORD_BITS-1:0]   gap_x,
  input  logic [COORD_BITS-1:0]   gap_y,
  output logic                    up_ready,
  input  logic                    dn_ready,
  output nrs_pkg::stage_ctl_t     s2_ctl,
  output logic [2*COORD_BITS-1:0] sq_x,
  output logic [2*COORD_BITS-1:0] sq_y
);
  import nrs_pkg::*;

  logic                    s2_valid_r;
  logic                    s2_qual_r;
  logic                    s2_last_r;
  logic [2*COORD_BITS-1:0] sq_x_r;
  logic [2*COORD_BITS-1:0] sq_y_r;
  logic [2*COORD_BITS-1:0] sq_x_nxt;
  logic [2*COORD_BITS-1:0] sq_y_nxt;
  logic                    s2_free;

  assign s2_free  = !s2_valid_r || dn_ready;
  assign up_ready = s2_free;

  always_comb begin
    sq_x_nxt = {{COORD_BITS{1'b0}}, gap_x} * {{COORD_BITS{1'b0}}, gap_x};
    sq_y_nxt = {{COORD_BITS{1'b0}}, gap_y} * {{COORD_BITS{1'b0}}, gap_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ctl.valid && s2_free) begin
      sq_x_r    <= sq_x_nxt;
      sq_y_r    <= sq_y_nxt;
      s2_qual_r <= s1_ctl.qual;
      s2_last_r <= s1_ctl.last;
    end
  end

  assign s2_ctl.valid = s2_valid_r;
  assign s2_ctl.qual  = s2_qual_r;
  assign s2_ctl.last  = s2_last_r;
  assign sq_x         = sq_x_r;
  assign sq_y         = sq_y_r;

endmodule

// ----- sv/nrs_accum.sv -----
// Running best-distance tracker and result register for one rectangle list.
module nrs_accum #(
  parameter int COORD_BITS = 16,
  parameter int CAPACITY   = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  nrs_pkg::stage_ctl_t     s2_ctl,
  input  logic [2*COORD_BITS-1:0] sq_x,
  input  logic [2*COORD_BITS-1:0] sq_y,
  output logic                    up_ready,
  nrs_result_if.source            out_result,
  output nrs_pkg::acc_status_t    acc_stat
);
  import nrs_pkg::*;

  localparam int DW    = 2 * COORD_BITS + 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [DW-1:0]         best_r;
  logic [DW-1:0]         best_nxt;
  logic [INDEX_BITS-1:0] pos_r;
  logic [INDEX_BITS-1:0] pos_nxt;
  logic                  any_r;
  logic                  any_nxt;
  logic                  ovf_r;
  logic                  ovf_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;

  logic                  out_valid_r;
  logic                  out_found_r;
  logic [INDEX_BITS-1:0] out_index_r;
  logic                  out_ovf_r;
  logic                  out_found_nxt;
  logic [INDEX_BITS-1:0] out_index_nxt;
  logic                  out_ovf_nxt;

  logic [DW-1:0]         sum_sq;
  logic                  out_free;
  logic                  fire;
  logic                  last_fire;

  assign sum_sq    = {1'b0, sq_x} + {1'b0, sq_y};
  assign out_free  = !out_valid_r || out_result.ready;
  // Hold a last request until the result register is free.
  assign fire      = s2_ctl.valid && (!s2_ctl.last || out_free);
  assign last_fire = fire && s2_ctl.last;
  assign up_ready  = !s2_ctl.valid || fire;

  always_comb begin
    best_nxt = best_r;
    pos_nxt  = pos_r;
    any_nxt  = any_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    if (fire) begin
      if (cnt_r == CNT_W'(CAPACITY)) begin
        ovf_nxt = 1'b1;
      end else begin
        // Strictly smaller wins, so the earlier rectangle keeps a tie.
        if (s2_ctl.qual && (!any_r || sum_sq < best_r)) begin
          best_nxt = sum_sq;
          pos_nxt  = INDEX_BITS'(cnt_r);
          any_nxt  = 1'b1;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    out_found_nxt = any_nxt;
    out_index_nxt = any_nxt ? pos_nxt : '0;
    out_ovf_nxt   = ovf_nxt;
    if (last_fire) begin
      best_nxt = '1;
      pos_nxt  = '0;
      any_nxt  = 1'b0;
      ovf_nxt  = 1'b0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '1;
      pos_r  <= '0;
      any_r  <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      best_r <= best_nxt;
      pos_r  <= pos_nxt;
      any_r  <= any_nxt;
      ovf_r  <= ovf_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_result.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (last_fire) begin
      out_found_r <= out_found_nxt;
      out_index_r <= out_index_nxt;
      out_ovf_r   <= out_ovf_nxt;
    end
  end

  assign out_result.valid      = out_valid_r;
  assign out_result.found      = out_found_r;
  assign out_result.best_index = out_index_r;
  assign out_result.overflow   = out_ovf_r;

  assign acc_stat.last_fire  = last_fire;
  assign acc_stat.list_clear = (cnt_r == '0) && !any_r && !ovf_r;

endmodule

// ----- sv/nearest_rect_select_top.sv -----
// Top level of the nearest rectangle select block.
// Picks, from a streamed list of rectangles, the first one closest to a caret
// point. Registers caret_x (index 0) and caret_y (index 1) are written through
// cfg_we / cfg_index / cfg_data; the user writes them only while the block is
// idle, which the block does not enforce. in_rect takes one rectangle request
// per cycle while ready is high; last_rect closes the list. Rectangles with
// zero or negative width or height are skipped. The distance is the sum of the
// squared per-axis gaps from the caret to the rectangle. out_result gives one
// result per list: found, best_index, overflow. Items past the capacity of
// min(MAX_RECTS, 256) are not compared and set overflow. Requests pass through
// a four-register pipeline (input, gap, square, best/result); a last request
// loads the result register as it leaves the square stage.
// Reset clears the pipeline, the list state and both caret registers.
// When out_result stalls, the pipeline keeps taking non-last requests; a last
// request waits in the square stage, and in_rect drops ready once the stages
// behind it fill.
`include "nearest_rect_select_top_macros.svh"

module nearest_rect_select_top #(
  parameter int MAX_RECTS  = nrs_pkg::MAX_RECTS_DEF,
  parameter int COORD_BITS = nrs_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [nrs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data,
  nrs_rect_if.sink                            in_rect,
  nrs_result_if.source                        out_result
);
  import nrs_pkg::*;

  localparam int CAPACITY = (MAX_RECTS < INDEX_LIMIT) ? MAX_RECTS : INDEX_LIMIT;

  logic signed [COORD_BITS-1:0] caret_x_r;
  logic signed [COORD_BITS-1:0] caret_y_r;

  stage_ctl_t                   s1_ctl;
  stage_ctl_t                   s2_ctl;
  acc_status_t                  acc_stat;
  logic [COORD_BITS-1:0]        gap_x;
  logic [COORD_BITS-1:0]        gap_y;
  logic [2*COORD_BITS-1:0]      sq_x;
  logic [2*COORD_BITS-1:0]      sq_y;
  logic                         dist_up_ready;
  logic                         acc_up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caret_x_r <= '0;
      caret_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CARET_X: caret_x_r <= cfg_data;
        REG_CARET_Y: caret_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  nrs_gap #(
    .COORD_BITS (COORD_BITS)
  ) u_gap (
    .clk      (clk),
    .rst_n    (rst_n),
    .caret_x  (caret_x_r),
    .caret_y  (caret_y_r),
    .in_rect  (in_rect),
    .up_ready (dist_up_ready),
    .s1_ctl   (s1_ctl),
    .gap_x    (gap_x),
    .gap_y    (gap_y)
  );

  nrs_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_ctl   (s1_ctl),
    .gap_x    (gap_x),
    .gap_y    (gap_y),
    .up_ready (dist_up_ready),
    .dn_ready (acc_up_ready),
    .s2_ctl   (s2_ctl),
    .sq_x     (sq_x),
    .sq_y     (sq_y)
  );

  nrs_accum #(
    .COORD_BITS (COORD_BITS),
    .CAPACITY   (CAPACITY)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2_ctl     (s2_ctl),
    .sq_x       (sq_x),
    .sq_y       (sq_y),
    .up_ready   (acc_up_ready),
    .out_result (out_result),
    .acc_stat   (acc_stat)
  );

  `NRS_ASSERT_NEXT(a_list_clear, acc_stat.last_fire, acc_stat.list_clear, "list state kept after last request")
  `NRS_ASSERT_NOW(a_no_overwrite, out_result.valid && !out_result.ready, !acc_stat.last_fire, "result overwritten while stalled")
  `NRS_ASSERT_NOW(a_stall_cause, !in_rect.ready, s1_ctl.valid && s2_ctl.valid, "input stalled with an empty stage")
  `NRS_ASSERT_NOW(a_empty_index, out_result.valid && !out_result.found, out_result.best_index == '0, "index set with nothing found")

endmodule

// ----- dv/tb_nearest_rect_select_top.sv -----
// Testbench for nearest_rect_select_top: directed and random rectangle lists checked against a local predictor.
module tb_nearest_rect_select_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nrs_pkg::*;

  localparam int COORD_W       = COORD_BITS_DEF;
  localparam int RECT_CAPACITY = (MAX_RECTS_DEF < INDEX_LIMIT) ? MAX_RECTS_DEF : INDEX_LIMIT;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 120;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] h;
    logic                      last;
  } rect_req_t;

  typedef struct {
    logic                  found;
    logic [INDEX_BITS-1:0] best_index;
    logic                  overflow;
  } pick_t;

  typedef enum {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_MOSTLY,
    RDY_BLOCKED
  } ready_mode_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic [COORD_W-1:0] cfg_data;

  nrs_rect_if #(.COORD_BITS(COORD_W)) rect_ch ();
  nrs_result_if result_ch ();

  nearest_rect_select_top #(
    .MAX_RECTS (MAX_RECTS_DEF),
    .COORD_BITS(COORD_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_rect   (rect_ch.sink),
    .out_result(result_ch.source)
  );

  always #5 clk = ~clk;

  // Predictor state: caret copy and the running list selection.
  logic signed [COORD_W-1:0] caret_x = '0;
  logic signed [COORD_W-1:0] caret_y = '0;
  longint unsigned           list_best_dist = '1;
  int                        list_best_pos = 0;
  bit                        list_found = 1'b0;
  int                        list_count = 0;
  bit                        list_overflow = 1'b0;

  rect_req_t   rects_to_send[$];
  pick_t       picks_due[$];
  rect_req_t   prev_rect;
  logic        rect_fire = 1'b0;
  int          send_gap = 0;
  int          send_burst = 1;
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          ready_left = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          items_queued = 0;

  function automatic longint unsigned axis_gap(longint pt, longint start, longint size);
    longint stop;
    stop = start + size - 1;
    if (pt < start) return start - pt;
    if (pt > stop) return pt - stop;
    return 0;
  endfunction

  task automatic fold_rect(input rect_req_t r);
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned sq_sum;
    pick_t           pick;
    if (list_count >= RECT_CAPACITY) begin
      list_overflow = 1'b1;
    end else begin
      if (r.w > 0 && r.h > 0) begin
        dx = axis_gap(caret_x, r.x, r.w);
        dy = axis_gap(caret_y, r.y, r.h);
        sq_sum = dx * dx + dy * dy;
        if (!list_found || sq_sum < list_best_dist) begin
          list_best_dist = sq_sum;
          list_best_pos = list_count;
          list_found = 1'b1;
        end
      end
      list_count++;
    end
    if (r.last) begin
      pick.found = list_found;
      pick.best_index = list_found ? list_best_pos[INDEX_BITS-1:0] : '0;
      pick.overflow = list_overflow;
      picks_due.push_back(pick);
      list_best_dist = '1;
      list_best_pos = 0;
      list_found = 1'b0;
      list_count = 0;
      list_overflow = 1'b0;
    end
  endtask

  function automatic logic [COORD_W-1:0] rand_extent();
    case ($urandom_range(0, 9))
      0, 1, 2: return COORD_W'($urandom_range(1, 40));
      3:       return COORD_W'($urandom());
      4:       return '0;
      5:       return {1'b1, (COORD_W-1)'($urandom())};
      default: return COORD_W'($urandom_range(1, 200));
    endcase
  endfunction

  function automatic rect_req_t make_rect(logic last);
    rect_req_t r;
    if ($urandom_range(0, 7) == 0) begin
      r = prev_rect;
    end else if ($urandom_range(0, 9) < 7) begin
      r.x = COORD_W'(int'(caret_x) + int'($urandom_range(0, 128)) - 64);
      r.y = COORD_W'(int'(caret_y) + int'($urandom_range(0, 128)) - 64);
      r.w = rand_extent();
      r.h = rand_extent();
    end else begin
      r.x = COORD_W'($urandom());
      r.y = COORD_W'($urandom());
      r.w = rand_extent();
      r.h = rand_extent();
    end
    r.last = last;
    return r;
  endfunction

  task automatic push_rect(int x, int y, int w, int h, logic last);
    rect_req_t r;
    r.x = COORD_W'(x);
    r.y = COORD_W'(y);
    r.w = COORD_W'(w);
    r.h = COORD_W'(h);
    r.last = last;
    rects_to_send.push_back(r);
    items_queued++;
  endtask

  task automatic queue_list(int len);
    rect_req_t r;
    for (int i = 0; i < len; i++) begin
      r = make_rect(i == len - 1);
      prev_rect = r;
      rects_to_send.push_back(r);
      items_queued++;
    end
  endtask

  task automatic queue_random_list();
    queue_list(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12));
  endtask

  // Hold until every request is taken and every pick is back, then let the pipe settle.
  task automatic drain();
    while (rects_to_send.size() != 0 || picks_due.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_caret(cfg_reg_t idx, logic [COORD_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_CARET_X) caret_x = value;
    else caret_y = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic note_error(string msg);
    if (mismatches < 10) $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      rect_ch.valid <= 1'b0;
    end else begin
      if (rect_fire) void'(rects_to_send.pop_front());
      if (rect_ch.valid && !rect_fire) begin
        // hold the request until it is taken
      end else if (send_gap > 0 || rects_to_send.size() == 0) begin
        rect_ch.valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        rect_ch.valid <= 1'b1;
        rect_ch.rect_x <= rects_to_send[0].x;
        rect_ch.rect_y <= rects_to_send[0].y;
        rect_ch.rect_width <= rects_to_send[0].w;
        rect_ch.rect_height <= rects_to_send[0].h;
        rect_ch.last_rect <= rects_to_send[0].last;
        send_burst--;
        if (send_burst <= 0) begin
          send_burst = $urandom_range(1, 40);
          send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Result receiver: stall pattern switches between randomly chosen modes, each run for a random length.
  always @(negedge clk) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (ready_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 4));
        ready_left = (ready_mode == RDY_BLOCKED) ? $urandom_range(5, 40) : $urandom_range(20, 200);
      end
      ready_left--;
      case (ready_mode)
        RDY_ALWAYS: result_ch.ready <= 1'b1;
        RDY_COIN:   result_ch.ready <= ($urandom_range(0, 1) == 1);
        RDY_SPARSE: result_ch.ready <= (ready_left % 8 == 0);
        RDY_MOSTLY: result_ch.ready <= ($urandom_range(0, 9) < 8);
        default:    result_ch.ready <= 1'b0;
      endcase
    end
  end

  // Monitor: predict on each taken request, check each taken result.
  always @(posedge clk) begin
    rect_req_t seen;
    pick_t     want;
    rect_fire <= rst_n && rect_ch.valid && rect_ch.ready;
    if (rst_n && rect_ch.valid && rect_ch.ready) begin
      seen.x = rect_ch.rect_x;
      seen.y = rect_ch.rect_y;
      seen.w = rect_ch.rect_width;
      seen.h = rect_ch.rect_height;
      seen.last = rect_ch.last_rect;
      fold_rect(seen);
    end
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (picks_due.size() == 0) begin
        note_error($sformatf("unexpected result found=%0b best_index=%0d overflow=%0b",
                             result_ch.found, result_ch.best_index, result_ch.overflow));
      end else begin
        want = picks_due.pop_front();
        if (result_ch.found !== want.found || result_ch.best_index !== want.best_index ||
            result_ch.overflow !== want.overflow)
          note_error($sformatf(
            "result mismatch: expected found=%0b best_index=%0d overflow=%0b, got %0b/%0d/%0b",
            want.found, want.best_index, want.overflow,
            result_ch.found, result_ch.best_index, result_ch.overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL nearest_rect_select_top");
      $finish;
    end
  end

  initial begin
    int cx_set[5];
    int cy_set[5];
    int phase_start;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_CARET_X;
    cfg_data = '0;
    rect_ch.valid = 1'b0;
    rect_ch.rect_x = '0;
    rect_ch.rect_y = '0;
    rect_ch.rect_width = '0;
    rect_ch.rect_height = '0;
    rect_ch.last_rect = 1'b0;
    result_ch.ready = 1'b0;
    prev_rect = '{default: '0};
    cx_set = '{-32768, 32767, -32768, 32767, 0};
    cy_set = '{-32768, 32767, 32767, -32768, 0};
    cx_set[4] = $urandom_range(0, 65535) - 32768;
    cy_set[4] = $urandom_range(0, 65535) - 32768;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed lists with the caret at its reset position.
    push_rect(-5, -5, 0, 10, 1'b1);                  // nothing qualifies
    push_rect(-5, -5, 10, -1, 1'b0);
    push_rect(0, 0, -32768, -32768, 1'b0);
    push_rect(-32768, -32768, 32767, 32767, 1'b0);
    push_rect(32767, 32767, 32767, 32767, 1'b0);
    push_rect(-3, -3, 7, 7, 1'b0);                   // caret inside
    push_rect(-3, -3, 7, 7, 1'b0);                   // equal distance, earlier kept
    push_rect(1, 1, 1, 1, 1'b1);
    push_rect(10, 0, 5, 5, 1'b0);
    push_rect(0, -10, 5, 5, 1'b0);
    push_rect(1, 0, 1, 1, 1'b0);
    push_rect(-1, 0, 1, 1, 1'b0);
    push_rect(0, 0, 1, 1, 1'b1);                     // single-cell hit on the caret
    push_rect(-20, -20, 1, 1, 1'b1);
    push_rect(-32768, 32767, 1, 1, 1'b1);
    while (items_queued < 15 + RANDOM_ITEMS) queue_random_list();
    drain();

    for (int p = 0; p < 5; p++) begin
      if ($urandom_range(0, 1) == 1) begin
        write_caret(REG_CARET_X, COORD_W'(cx_set[p]));
        write_caret(REG_CARET_Y, COORD_W'(cy_set[p]));
      end else begin
        write_caret(REG_CARET_Y, COORD_W'(cy_set[p]));
        write_caret(REG_CARET_X, COORD_W'(cx_set[p]));
      end
      // One full list at capacity, one that runs past it.
      if (p == 1) queue_list(RECT_CAPACITY);
      if (p == 3) queue_list(RECT_CAPACITY + 2);
      phase_start = items_queued;
      while (items_queued < phase_start + RANDOM_ITEMS / 2) queue_random_list();
      drain();
      while (items_queued < phase_start + RANDOM_ITEMS) queue_random_list();
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && picks_due.size() == 0) begin
      $display("PASS nearest_rect_select_top");
    end else begin
      $display("FAIL nearest_rect_select_top");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/nrs_pkg.sv
sv/nrs_rect_if.sv
sv/nrs_result_if.sv
sv/nrs_gap.sv
sv/nrs_dist.sv
sv/nrs_accum.sv
sv/nearest_rect_select_top.sv
dv/tb_nearest_rect_select_top.sv
